// ===== rtl/uer_pkg.sv =====
// Shared types, register codes and defaults for the ultrasonic echo ranger.
package uer_pkg;

  // Defaults for the top-level parameters.
  localparam int DefCountWidth = 16;
  localparam int DefMaxAverage = 16;

  // Settle, wait and pulse counts are at least this wide.
  localparam int TimerWidth = 16;

  // The distance field is fixed at 17 bits and saturates.
  localparam int DistWidth = 17;
  localparam logic [DistWidth-1:0] DistMax = 17'd131071;

  // Configuration port widths.
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_AVG_COUNT       = 3'd0,
    CFG_TIMEOUT_LIMIT   = 3'd1,
    CFG_ECHO_TIMEOUT_US = 3'd2,
    CFG_SETTLE_US       = 3'd3,
    CFG_TRIGGER_US      = 3'd4
  } cfg_idx_e;

  // Register reset values.
  localparam logic [4:0]  AvgCountRst      = 5'd3;
  localparam logic [3:0]  TimeoutLimitRst  = 4'd3;
  localparam logic [15:0] EchoTimeoutUsRst = 16'd1400;
  localparam logic [15:0] SettleUsRst      = 16'd15000;
  localparam logic [7:0]  TriggerUsRst     = 8'd10;

  // Configuration registers as seen by the tick logic.
  typedef struct packed {
    logic [4:0]  avg_count;
    logic [3:0]  timeout_limit;
    logic [15:0] echo_timeout_us;
    logic [15:0] settle_us;
    logic [7:0]  trigger_us;
  } cfg_t;

  // One input request: a microsecond tick.
  typedef struct packed {
    logic start_req;
    logic echo_in;
  } in_req_t;

  // One result per tick.
  typedef struct packed {
    logic                 trigger_out;
    logic                 busy_res;
    logic                 done_res;
    logic                 failed;
    logic [DistWidth-1:0] distance;
  } out_res_t;

  // Measurement phase of the ranging state machine.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SETTLE  = 3'd1,
    PH_TRIG    = 3'd2,
    PH_WAIT    = 3'd3,
    PH_MEASURE = 3'd4
  } phase_e;

  // Status of one processed tick, from the tick core to the sequencer.
  typedef struct packed {
    logic trigger;
    logic busy;
    logic fin;
    logic fail;
  } tick_stat_t;

  // Handshake sequencer states.
  typedef enum logic [1:0] {
    SQ_READY    = 2'd0,
    SQ_DIV_LOAD = 2'd1,
    SQ_DIV_RUN  = 2'd2,
    SQ_EMIT     = 2'd3
  } seq_e;

endpackage

// ===== rtl/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: config, sequencer and output register.
//
// Each input request is one microsecond tick carrying start_req and the
// sampled echo level; each tick yields exactly one result carrying the
// trigger level, busy, done, failed and the averaged distance (0.01 cm).
// Input and output use valid/stall: a request moves when valid is high and
// stall is low. Configuration writes use cfg_valid_i/cfg_ready_o with a
// register index; ready is always high, and writes belong in idle periods.
// An ordinary tick's result is held in pend_q and then loaded into the
// output register out_q in the EMIT state; no new tick is taken until
// that handover. The tick that ends a good measurement runs the
// restoring divider, one quotient bit a cycle, in states DIV_LOAD and
// DIV_RUN before EMIT, and the next tick is taken once EMIT is done.
// The block accepts the next tick while the previous result still waits in
// the output register; while out_stall_i holds, it finishes that tick and
// then stalls its input. Reset clears the phase, counters and accumulators,
// drops out_valid_o and resets the configuration registers to defaults.
module ultrasonic_echo_ranger #(
  parameter int COUNT_WIDTH = uer_pkg::DefCountWidth,
  parameter int MAX_AVERAGE = uer_pkg::DefMaxAverage
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  uer_pkg::in_req_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output uer_pkg::out_res_t                  out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [uer_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [uer_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  import uer_pkg::*;

  localparam int SumW  = COUNT_WIDTH + $clog2(MAX_AVERAGE + 1);
  localparam int GoodW = $clog2(MAX_AVERAGE + 1);
  localparam int NumW  = SumW + 5;
  localparam int DenW  = $clog2(10 * MAX_AVERAGE + 1);

  cfg_t              cfg_q;
  seq_e              seq_q, seq_d;
  tick_stat_t        stat;
  logic [SumW-1:0]   width_sum;
  logic [GoodW-1:0]  n;
  logic              in_accept;
  logic              out_free;
  logic              emit;
  logic              div_start;
  logic              div_done;
  logic [NumW-1:0]   div_num;
  logic [DenW-1:0]   div_den;
  logic [NumW-1:0]   quot;
  logic [DistWidth-1:0] dist_sat;
  out_res_t          pend_q;
  out_res_t          out_q;
  logic              out_valid_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.avg_count       <= AvgCountRst;
      cfg_q.timeout_limit   <= TimeoutLimitRst;
      cfg_q.echo_timeout_us <= EchoTimeoutUsRst;
      cfg_q.settle_us       <= SettleUsRst;
      cfg_q.trigger_us      <= TriggerUsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_AVG_COUNT:       cfg_q.avg_count       <= cfg_data_i[4:0];
        CFG_TIMEOUT_LIMIT:   cfg_q.timeout_limit   <= cfg_data_i[3:0];
        CFG_ECHO_TIMEOUT_US: cfg_q.echo_timeout_us <= cfg_data_i;
        CFG_SETTLE_US:       cfg_q.settle_us       <= cfg_data_i;
        CFG_TRIGGER_US:      cfg_q.trigger_us      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Tick processing.
  uer_tick_core #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .MAX_AVERAGE(MAX_AVERAGE)
  ) u_tick_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_en_i  (in_accept),
    .req_i      (in_data_i),
    .cfg_i      (cfg_q),
    .stat_o     (stat),
    .width_sum_o(width_sum),
    .n_o        (n)
  );

  // Average: (sum * 17 + 5n) / (10n), built from shifts and adds.
  assign div_num = (NumW'(width_sum) << 4) + NumW'(width_sum)
                 + (NumW'(n) << 2) + NumW'(n);
  assign div_den = (DenW'(n) << 3) + (DenW'(n) << 1);

  uer_divider #(
    .NUM_W(NumW),
    .DEN_W(DenW)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign dist_sat = (|quot[NumW-1:DistWidth]) ? DistMax : quot[DistWidth-1:0];

  // Sequencer next state.
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SQ_READY: begin
        if (in_valid_i) begin
          seq_d = (stat.fin && !stat.fail) ? SQ_DIV_LOAD : SQ_EMIT;
        end
      end
      SQ_DIV_LOAD: seq_d = SQ_DIV_RUN;
      SQ_DIV_RUN:  if (div_done) seq_d = SQ_EMIT;
      SQ_EMIT:     if (out_free) seq_d = SQ_READY;
      default:     seq_d = SQ_READY;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = (seq_q != SQ_READY);
    div_start  = (seq_q == SQ_DIV_LOAD);
    emit       = (seq_q == SQ_EMIT) && out_free;
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SQ_READY;
    end else begin
      seq_q <= seq_d;
    end
  end

  // Pending result of the tick being finished.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_q.trigger_out <= stat.trigger;
      pend_q.busy_res    <= stat.busy;
      pend_q.done_res    <= stat.fin;
      pend_q.failed      <= stat.fail;
      pend_q.distance    <= '0;
    end else if (seq_q == SQ_DIV_RUN && div_done) begin
      pend_q.distance <= dist_sat;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= pend_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A distance is only reported on a successful done tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.distance == '0) ||
                    (out_data_o.done_res && !out_data_o.failed))
    else $error("distance reported outside a successful done tick");

  // Failed is only raised together with done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.failed |-> out_data_o.done_res)
    else $error("failed without done");

  // An accepted tick stalls the input until its result is handed over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input accepted again before result emitted");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (seq_q == SQ_DIV_RUN))
    else $error("divider finished outside its wait state");

endmodule

// ===== rtl/uer_divider.sv =====
// Restoring divider: one quotient bit per cycle.
module uer_divider #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh = {rem_q, num_q[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = (rem_sh >= {1'b0, den_q});
    rem_d  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    num_d  = {num_q[NUM_W-2:0], ge};
  end

  // Control: count the steps and flag the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out while quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== rtl/uer_tick_core.sv =====
// Ranging state machine: phases, tick counter and reading accumulators.
module uer_tick_core #(
  parameter int  COUNT_WIDTH = uer_pkg::DefCountWidth,
  parameter int  MAX_AVERAGE = uer_pkg::DefMaxAverage,
  localparam int SumW  = COUNT_WIDTH + $clog2(MAX_AVERAGE + 1),
  localparam int GoodW = $clog2(MAX_AVERAGE + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_en_i,
  input  uer_pkg::in_req_t    req_i,
  input  uer_pkg::cfg_t       cfg_i,
  output uer_pkg::tick_stat_t stat_o,
  output logic [SumW-1:0]     width_sum_o,
  output logic [GoodW-1:0]    n_o
);

  import uer_pkg::*;

  localparam int TickW = (COUNT_WIDTH > TimerWidth) ? COUNT_WIDTH : TimerWidth;
  localparam logic [TickW-1:0] CountMax = TickW'({COUNT_WIDTH{1'b1}});

  phase_e            phase_q, phase_d;
  logic [TickW-1:0]  tick_q, tick_d, tick_inc;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [GoodW-1:0]  good_q, good_d;
  logic [3:0]        to_q, to_d;
  logic [GoodW-1:0]  n;
  logic              boundary;
  logic              fin;
  logic              fail;

  // Effective reading count: zero acts as one, large values clamp.
  always_comb begin
    priority if (cfg_i.avg_count == 5'd0) begin
      n = GoodW'(1);
    end else if (32'(cfg_i.avg_count) > 32'(MAX_AVERAGE)) begin
      n = GoodW'(MAX_AVERAGE);
    end else begin
      n = GoodW'(cfg_i.avg_count);
    end
  end

  // Next state for one accepted tick.
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    sum_d    = sum_q;
    good_d   = good_q;
    to_d     = to_q;
    boundary = 1'b0;
    fin      = 1'b0;
    fail     = 1'b0;
    tick_inc = tick_q + 1'b1;
    if (tick_en_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (req_i.start_req) begin
            sum_d   = '0;
            good_d  = '0;
            to_d    = '0;
            tick_d  = '0;
            phase_d = PH_SETTLE;
          end
        end
        PH_SETTLE: begin
          tick_d = tick_inc;
          if (tick_inc >= TickW'(cfg_i.settle_us)) boundary = 1'b1;
        end
        PH_TRIG: begin
          if (tick_q >= TickW'(cfg_i.trigger_us)) begin
            phase_d = PH_WAIT;
            tick_d  = '0;
          end else begin
            tick_d = tick_inc;
          end
        end
        PH_WAIT: begin
          if (tick_q >= TickW'(cfg_i.echo_timeout_us)) begin
            to_d     = to_q + 1'b1;
            boundary = 1'b1;
          end else if (req_i.echo_in) begin
            phase_d = PH_MEASURE;
            tick_d  = '0;
          end else begin
            tick_d = tick_inc;
          end
        end
        PH_MEASURE: begin
          if (req_i.echo_in) begin
            if (tick_q < CountMax) tick_d = tick_inc;
          end else begin
            sum_d    = sum_q + SumW'(tick_q[COUNT_WIDTH-1:0]);
            good_d   = good_q + 1'b1;
            boundary = 1'b1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
      // Reading boundary: fail, finish or fire another pulse.
      if (boundary) begin
        priority if (to_d >= cfg_i.timeout_limit) begin
          fin     = 1'b1;
          fail    = 1'b1;
          phase_d = PH_IDLE;
        end else if (good_d >= n) begin
          fin     = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          phase_d = PH_TRIG;
          tick_d  = TickW'(1);
        end
      end
    end
  end

  // Status for the tick being processed.
  always_comb begin
    stat_o.trigger = (phase_d == PH_TRIG);
    stat_o.busy    = (phase_d != PH_IDLE);
    stat_o.fin     = fin;
    stat_o.fail    = fail;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      sum_q   <= '0;
      good_q  <= '0;
      to_q    <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      sum_q   <= sum_d;
      good_q  <= good_d;
      to_q    <= to_d;
    end
  end

  assign width_sum_o = sum_q;
  assign n_o         = n;

endmodule
